/* src/skt_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the sorted key table
// no dependencies; used by skt_cell and sorted_key_table_unit
package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_RANGE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_CMP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t                   op;
    logic signed [KEY_W-1:0]    key;
    logic signed [KEY_W-1:0]    key_high;
    logic        [HANDLE_W-1:0] handle;
  } cell_cmd_t;

  // compare results held in each cell
  typedef struct packed {
    logic at;  // unoccupied, or key >= search key
    logic eq;  // occupied and key == search key
    logic le;  // key <= upper bound
  } cell_flags_t;

endpackage

/* src/sorted_key_table_unit.sv */
`timescale 1ns / 1ps
// top level of the sorted key table: request sequencer over a chain of skt_cell
// depends on skt_pkg and skt_cell
//
// usage:
//   a request (in_mode, in_key, in_key_high, in_handle) is taken on a clock edge
//   with start high and busy low. busy drops in the cycle that carries the last
//   result of that request.
//   results appear on out_* for exactly one cycle each, marked by out_strobe;
//   out_last flags the final result of a request. the receiver cannot stall.
//   timing: every cell compares its entry with the key in state S_CMP, the next
//   cycle (S_EXEC) picks the position and shifts the chain one step for insert
//   or delete. insert, lookup, delete and an empty range query register their
//   result in S_EXEC; busy is already low in the cycle that shows it, so the next
//   request can be taken on the edge that ends that cycle. a range query of n
//   matching entries steps through S_RANGE and drives one result per cycle.
//   the per-entry range stepping through the cell read mux sets the range rate.
//   reset empties the table (entry count zero) and needs no clearing pass.
module sorted_key_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_mode,
  input  logic signed [skt_pkg::KEY_W-1:0]    in_key,
  input  logic signed [skt_pkg::KEY_W-1:0]    in_key_high,
  input  logic [skt_pkg::HANDLE_W-1:0]        in_handle,
  output logic                                out_strobe,
  output logic [2:0]                          out_status,
  output logic signed [skt_pkg::KEY_W-1:0]    out_found_key,
  output logic [skt_pkg::HANDLE_W-1:0]        out_found_handle,
  output logic [skt_pkg::IDX_W-1:0]           out_position,
  output logic                                out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_RANGE
  } state_t;

  state_t                             state_r, state_nxt;
  skt_pkg::mode_t                     mode_r;
  logic signed [skt_pkg::KEY_W-1:0]   key_r, key_high_r;
  logic [skt_pkg::HANDLE_W-1:0]       handle_r;
  logic [skt_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [skt_pkg::IDX_W-1:0]          ptr_r, ptr_nxt;

  logic                               strobe_r, strobe_nxt;
  skt_pkg::status_t                   status_r, status_nxt;
  logic signed [skt_pkg::KEY_W-1:0]   fkey_r, fkey_nxt;
  logic [skt_pkg::HANDLE_W-1:0]       fhandle_r, fhandle_nxt;
  logic [skt_pkg::IDX_W-1:0]          pos_r, pos_nxt;
  logic                               last_r, last_nxt;

  skt_pkg::cell_cmd_t                 cmd;
  skt_pkg::cell_flags_t               flags [skt_pkg::CAPACITY];
  logic signed [skt_pkg::KEY_W-1:0]   cell_key [skt_pkg::CAPACITY];
  logic [skt_pkg::HANDLE_W-1:0]       cell_handle [skt_pkg::CAPACITY];
  logic [skt_pkg::CAPACITY-1:0]       occ, at_vec, eq_vec, le_vec;

  logic [skt_pkg::CNT_W-1:0]          idx;
  logic [skt_pkg::IDX_W-1:0]          idx_s;
  logic                               hit, idx_in;
  logic [skt_pkg::CNT_W-1:0]          ptr_inc;
  logic                               more;

  // ---------------------------------------------------------------- cell chain
  genvar gi;
  generate
    for (gi = 0; gi < skt_pkg::CAPACITY; gi++) begin : g_cell
      logic                               l_at;
      logic signed [skt_pkg::KEY_W-1:0]   l_key, r_key;
      logic [skt_pkg::HANDLE_W-1:0]       l_handle, r_handle;

      if (gi == 0) begin : g_first
        assign l_at     = 1'b0;
        assign l_key    = cell_key[gi];
        assign l_handle = cell_handle[gi];
      end else begin : g_mid
        assign l_at     = flags[gi-1].at;
        assign l_key    = cell_key[gi-1];
        assign l_handle = cell_handle[gi-1];
      end
      if (gi == skt_pkg::CAPACITY - 1) begin : g_last
        assign r_key    = cell_key[gi];
        assign r_handle = cell_handle[gi];
      end else begin : g_inner
        assign r_key    = cell_key[gi+1];
        assign r_handle = cell_handle[gi+1];
      end

      assign occ[gi]    = (skt_pkg::CNT_W'(gi) < count_r);
      assign at_vec[gi] = flags[gi].at;
      assign eq_vec[gi] = flags[gi].eq;
      assign le_vec[gi] = flags[gi].le;

      skt_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .occ          (occ[gi]),
        .left_at      (l_at),
        .left_key     (l_key),
        .left_handle  (l_handle),
        .right_key    (r_key),
        .right_handle (r_handle),
        .key_o        (cell_key[gi]),
        .handle_o     (cell_handle[gi]),
        .flags_o      (flags[gi])
      );
    end
  endgenerate

  // first cell at or past the search key
  always_comb begin
    idx = skt_pkg::CNT_W'(skt_pkg::CAPACITY);
    for (int i = skt_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (at_vec[i]) idx = skt_pkg::CNT_W'(i);
    end
  end

  assign idx_s   = idx[skt_pkg::IDX_W-1:0];
  assign idx_in  = (idx < count_r);
  assign hit     = |eq_vec;
  assign ptr_inc = skt_pkg::CNT_W'(ptr_r) + skt_pkg::CNT_W'(1);
  assign more    = (ptr_inc < count_r) && le_vec[ptr_inc[skt_pkg::IDX_W-1:0]];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    fkey_nxt    = fkey_r;
    fhandle_nxt = fhandle_r;
    pos_nxt     = pos_r;
    last_nxt    = last_r;

    cmd.op       = skt_pkg::OP_HOLD;
    cmd.key      = key_r;
    cmd.key_high = key_high_r;
    cmd.handle   = handle_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = skt_pkg::OP_CMP;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        strobe_nxt  = 1'b1;
        last_nxt    = 1'b1;
        state_nxt   = S_IDLE;
        fkey_nxt    = key_r;
        fhandle_nxt = '0;
        pos_nxt     = '0;
        unique case (mode_r)
          skt_pkg::MODE_INSERT: begin
            if (hit) begin
              status_nxt  = skt_pkg::ST_DUP;
              fkey_nxt    = cell_key[idx_s];
              fhandle_nxt = cell_handle[idx_s];
              pos_nxt     = idx_s;
            end else if (count_r == skt_pkg::CNT_W'(skt_pkg::CAPACITY)) begin
              status_nxt = skt_pkg::ST_FULL;
            end else begin
              cmd.op      = skt_pkg::OP_INSERT;
              count_nxt   = count_r + skt_pkg::CNT_W'(1);
              status_nxt  = skt_pkg::ST_OK;
              fhandle_nxt = handle_r;
              pos_nxt     = idx_s;
            end
          end
          skt_pkg::MODE_LOOKUP, skt_pkg::MODE_DELETE: begin
            if (hit) begin
              status_nxt  = skt_pkg::ST_OK;
              fkey_nxt    = cell_key[idx_s];
              fhandle_nxt = cell_handle[idx_s];
              pos_nxt     = idx_s;
              if (mode_r == skt_pkg::MODE_DELETE) begin
                cmd.op    = skt_pkg::OP_DELETE;
                count_nxt = count_r - skt_pkg::CNT_W'(1);
              end
            end else begin
              status_nxt = skt_pkg::ST_NOTFOUND;
            end
          end
          skt_pkg::MODE_RANGE: begin
            if (idx_in && le_vec[idx_s]) begin
              strobe_nxt = 1'b0;
              ptr_nxt    = idx_s;
              state_nxt  = S_RANGE;
            end else begin
              status_nxt = skt_pkg::ST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_RANGE: begin
        strobe_nxt  = 1'b1;
        status_nxt  = skt_pkg::ST_OK;
        fkey_nxt    = cell_key[ptr_r];
        fhandle_nxt = cell_handle[ptr_r];
        pos_nxt     = ptr_r;
        last_nxt    = !more;
        if (more) begin
          ptr_nxt = ptr_inc[skt_pkg::IDX_W-1:0];
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
    ptr_r     <= ptr_nxt;
    status_r  <= status_nxt;
    fkey_r    <= fkey_nxt;
    fhandle_r <= fhandle_nxt;
    pos_r     <= pos_nxt;
    last_r    <= last_nxt;
    // request fields captured on the input transfer
    if (state_r == S_IDLE && start) begin
      mode_r     <= skt_pkg::mode_t'(in_mode);
      key_r      <= in_key;
      key_high_r <= in_key_high;
      handle_r   <= in_handle;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_found_key    = fkey_r;
  assign out_found_handle = fhandle_r;
  assign out_position     = pos_r;
  assign out_last         = last_r;

endmodule

/* src/skt_cell.sv */
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry, compares it, shifts left or right
// depends on skt_pkg
module skt_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  skt_pkg::cell_cmd_t                 cmd,
  input  logic                               occ,
  input  logic                               left_at,
  input  logic signed [skt_pkg::KEY_W-1:0]   left_key,
  input  logic        [skt_pkg::HANDLE_W-1:0] left_handle,
  input  logic signed [skt_pkg::KEY_W-1:0]   right_key,
  input  logic        [skt_pkg::HANDLE_W-1:0] right_handle,
  output logic signed [skt_pkg::KEY_W-1:0]   key_o,
  output logic        [skt_pkg::HANDLE_W-1:0] handle_o,
  output skt_pkg::cell_flags_t               flags_o
);

  logic signed [skt_pkg::KEY_W-1:0]    key_r;
  logic        [skt_pkg::HANDLE_W-1:0] handle_r;
  skt_pkg::cell_flags_t                flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (cmd.op == skt_pkg::OP_CMP) begin
      flags_r.at <= !occ || (key_r >= cmd.key);
      flags_r.eq <= occ && (key_r == cmd.key);
      flags_r.le <= (key_r <= cmd.key_high);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      skt_pkg::OP_INSERT: begin
        // cells past the insert point take their left neighbor; the cell at the insert point takes the new entry
        if (left_at) begin
          key_r    <= left_key;
          handle_r <= left_handle;
        end else if (flags_r.at) begin
          key_r    <= cmd.key;
          handle_r <= cmd.handle;
        end
      end
      skt_pkg::OP_DELETE: begin
        if (flags_r.at) begin
          key_r    <= right_key;
          handle_r <= right_handle;
        end
      end
      default: ;
    endcase
  end

  assign key_o    = key_r;
  assign handle_o = handle_r;
  assign flags_o  = flags_r;

endmodule
